// File: hdl/cqem_pkg.sv
// ----------------------------------------------------------------------------
// cqem_pkg
// Shared types and constants of the circular quarter extreme mean core.
// ----------------------------------------------------------------------------
`default_nettype none

package cqem_pkg;

   // Fixed field widths of the item and the result
   localparam int VALUE_BITS = 16;
   localparam int SUM_BITS   = VALUE_BITS + 2;
   localparam int START_BITS = 4;

   // Divide by three: multiply by ceil(2^17 / 3), keep the bits above 17.
   // Exact for magnitudes below 2^17, which covers any three-value sum.
   localparam int MAG_BITS   = SUM_BITS - 1;
   localparam int DIV3_SHIFT = 17;
   localparam int PROD_BITS  = MAG_BITS + VALUE_BITS;
   localparam logic [VALUE_BITS-1:0] DIV3_RECIP = 16'd43691;

   // One input item: one month of a row
   typedef struct packed {
      logic signed [VALUE_BITS-1:0] select_value;
      logic                         select_missing;
      logic signed [VALUE_BITS-1:0] average_value;
      logic                         average_missing;
   } req_type;

   // One result item: the chosen quarter of a row
   typedef struct packed {
      logic [START_BITS-1:0]        quarter_start;
      logic signed [VALUE_BITS-1:0] quarter_avg;
      logic                         mean_missing;
   } rsp_type;

   // Row outcome handed from the window scan to the result stage
   typedef struct packed {
      logic [START_BITS-1:0]      start;
      logic signed [SUM_BITS-1:0] average_sum;
      logic                       missing;
   } fin_type;

endpackage

`default_nettype wire

// File: hdl/cqem_div3.sv
// ----------------------------------------------------------------------------
// cqem_div3
// Signed window sum divided by three, truncated toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module cqem_div3 import cqem_pkg::*; (
   input  wire logic signed [SUM_BITS-1:0]   sum,
   output logic signed [VALUE_BITS-1:0]      quotient
);

   logic                   negative;
   logic [SUM_BITS-1:0]    magnitude;
   logic [PROD_BITS-1:0]   product;
   logic [VALUE_BITS-1:0]  mag_quotient;

   // Work on the magnitude so the result truncates toward zero
   assign negative     = sum[SUM_BITS-1];
   assign magnitude    = negative ? (-sum) : sum;
   assign product      = PROD_BITS'(magnitude[MAG_BITS-1:0]) * PROD_BITS'(DIV3_RECIP);
   assign mag_quotient = product[DIV3_SHIFT+VALUE_BITS-1:DIV3_SHIFT];

   // Restore the sign
   assign quotient = negative ? (-mag_quotient) : mag_quotient;

endmodule

`default_nettype wire

// File: hdl/cqem_window.sv
// ----------------------------------------------------------------------------
// cqem_window
// Input register and row state: tracks the best circular quarter of a row
// and hands the row outcome to the result stage after the last month.
// ----------------------------------------------------------------------------
`default_nettype none

module cqem_window import cqem_pkg::*; #(
   parameter int MONTHS = 12
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    find_minimum,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         fin_valid,
   input  wire logic    fin_take,
   output fin_type      fin_data
);

   localparam int CW = $clog2(MONTHS);
   localparam logic [CW-1:0] LAST_MONTH = CW'(MONTHS - 1);
   localparam logic [CW-1:0] WRAP_START = CW'(MONTHS - 2);

   // Input register
   logic    in_valid_ff;
   req_type in_data_ff;

   // Row state
   logic [CW-1:0]                cnt_ff, cnt_in;
   logic                         any_sm_ff, any_sm_in;
   logic signed [VALUE_BITS-1:0] first_sel_ff [2];
   logic signed [VALUE_BITS-1:0] first_avg_ff [2];
   logic                         first_am_ff  [2];
   logic signed [VALUE_BITS-1:0] rec_sel_ff   [2];
   logic signed [VALUE_BITS-1:0] rec_avg_ff   [2];
   logic                         rec_am_ff    [2];
   logic signed [SUM_BITS-1:0]   best_sum_ff, best_sum_in;
   logic [CW-1:0]                best_start_ff, best_start_in;
   logic signed [SUM_BITS-1:0]   best_avg_ff, best_avg_in;
   logic                         best_am_ff, best_am_in;

   // Result handoff register
   logic    fin_valid_ff;
   fin_type fin_ff, fin_in;

   logic is_last, in_move, in_free, fin_free, row_sm;
   logic signed [SUM_BITS-1:0] cur_sel, cur_avg;
   logic signed [SUM_BITS-1:0] a_sel, a_avg, b_sel, b_avg, c_sel, c_avg;
   logic a_am, b_am, c_am;

   // Handshake between the stages
   assign is_last   = (cnt_ff == LAST_MONTH);
   assign fin_free  = !fin_valid_ff || fin_take;
   assign in_move   = in_valid_ff && (!is_last || fin_free);
   assign in_free   = !in_valid_ff || in_move;
   assign req_stall = !in_free;
   assign fin_valid = fin_valid_ff;
   assign fin_data  = fin_ff;
   assign row_sm    = any_sm_ff || in_data_ff.select_missing;

   // Three-month sums: plain, wrapping in one or two months from row start
   assign cur_sel = SUM_BITS'(in_data_ff.select_value);
   assign cur_avg = SUM_BITS'(in_data_ff.average_value);
   assign a_sel = SUM_BITS'(rec_sel_ff[0]) + SUM_BITS'(rec_sel_ff[1]) + cur_sel;
   assign a_avg = SUM_BITS'(rec_avg_ff[0]) + SUM_BITS'(rec_avg_ff[1]) + cur_avg;
   assign a_am  = rec_am_ff[0] || rec_am_ff[1] || in_data_ff.average_missing;
   assign b_sel = SUM_BITS'(rec_sel_ff[1]) + cur_sel + SUM_BITS'(first_sel_ff[0]);
   assign b_avg = SUM_BITS'(rec_avg_ff[1]) + cur_avg + SUM_BITS'(first_avg_ff[0]);
   assign b_am  = rec_am_ff[1] || in_data_ff.average_missing || first_am_ff[0];
   assign c_sel = cur_sel + SUM_BITS'(first_sel_ff[0]) + SUM_BITS'(first_sel_ff[1]);
   assign c_avg = cur_avg + SUM_BITS'(first_avg_ff[0]) + SUM_BITS'(first_avg_ff[1]);
   assign c_am  = in_data_ff.average_missing || first_am_ff[0] || first_am_ff[1];

   // Compare the windows closed by this month against the best so far
   always_comb begin
      best_sum_in   = best_sum_ff;
      best_start_in = best_start_ff;
      best_avg_in   = best_avg_ff;
      best_am_in    = best_am_ff;
      if (cnt_ff >= CW'(2)) begin
         if ((cnt_ff == CW'(2)) ||
             (find_minimum ? (a_sel < best_sum_in) : (a_sel > best_sum_in))) begin
            best_sum_in   = a_sel;
            best_start_in = cnt_ff - CW'(2);
            best_avg_in   = a_avg;
            best_am_in    = a_am;
         end
      end
      if (is_last) begin
         if (find_minimum ? (b_sel < best_sum_in) : (b_sel > best_sum_in)) begin
            best_sum_in   = b_sel;
            best_start_in = WRAP_START;
            best_avg_in   = b_avg;
            best_am_in    = b_am;
         end
         if (find_minimum ? (c_sel < best_sum_in) : (c_sel > best_sum_in)) begin
            best_sum_in   = c_sel;
            best_start_in = LAST_MONTH;
            best_avg_in   = c_avg;
            best_am_in    = c_am;
         end
      end
   end

   // Advance the month count; clear the row at its end
   assign cnt_in    = is_last ? '0 : (cnt_ff + CW'(1));
   assign any_sm_in = is_last ? 1'b0 : row_sm;

   // Row outcome
   always_comb begin
      fin_in.start       = row_sm ? START_BITS'(MONTHS) : START_BITS'(best_start_in);
      fin_in.average_sum = best_avg_in;
      fin_in.missing     = row_sm || best_am_in;
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         fin_valid_ff <= 1'b0;
         cnt_ff       <= '0;
         any_sm_ff    <= 1'b0;
      end else begin
         if (in_free) begin
            in_valid_ff <= req_valid;
         end
         if (fin_free) begin
            fin_valid_ff <= in_move && is_last;
         end
         if (in_move) begin
            cnt_ff    <= cnt_in;
            any_sm_ff <= any_sm_in;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (in_free && req_valid) begin
         in_data_ff <= req_data;
      end
      if (in_move) begin
         best_sum_ff   <= best_sum_in;
         best_start_ff <= best_start_in;
         best_avg_ff   <= best_avg_in;
         best_am_ff    <= best_am_in;
         rec_sel_ff[0] <= rec_sel_ff[1];
         rec_avg_ff[0] <= rec_avg_ff[1];
         rec_am_ff[0]  <= rec_am_ff[1];
         rec_sel_ff[1] <= in_data_ff.select_value;
         rec_avg_ff[1] <= in_data_ff.average_value;
         rec_am_ff[1]  <= in_data_ff.average_missing;
         if (cnt_ff == CW'(0)) begin
            first_sel_ff[0] <= in_data_ff.select_value;
            first_avg_ff[0] <= in_data_ff.average_value;
            first_am_ff[0]  <= in_data_ff.average_missing;
         end
         if (cnt_ff == CW'(1)) begin
            first_sel_ff[1] <= in_data_ff.select_value;
            first_avg_ff[1] <= in_data_ff.average_value;
            first_am_ff[1]  <= in_data_ff.average_missing;
         end
      end
      if (fin_free && in_move && is_last) begin
         fin_ff <= fin_in;
      end
   end

   // Month count stays inside the row
   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      32'(cnt_ff) < MONTHS)
      else $error("month count out of range");

   // Closing a row restarts the count and the missing-selection flag
   a_row_clear: assert property (@(posedge clock) disable iff (reset)
      in_move && is_last |=> cnt_ff == '0 && !any_sm_ff)
      else $error("row not cleared after last month");

   // A row outcome is produced exactly when the last month moves on
   a_fin_load: assert property (@(posedge clock) disable iff (reset)
      fin_free |=> fin_valid_ff == $past(in_move && is_last))
      else $error("row outcome load mismatch");

endmodule

`default_nettype wire

// File: hdl/circular_quarter_extreme_mean_core.sv
// ----------------------------------------------------------------------------
// circular_quarter_extreme_mean_core
// Picks the circular three-month quarter with the greatest (or least)
// selection sum in each row of months and reports its mean.
// ----------------------------------------------------------------------------
// Usage:
// - Feed one month per item on req_*; every MONTHS items form one row.
//   The last month of a row yields one result item on rsp_*, others none.
// - csr_write_enable/csr_write_data set find_minimum (0 greatest sum,
//   1 least); write it only while the core is idle.
// - One item enters per cycle while req_stall is low. The path is
//   input register, window scan, row register, divide-by-three,
//   result register.
// - The row scan compares up to three windows in the cycle of the last
//   month; the mean uses one 17x16 multiply in the result stage.
// - While rsp_stall is high the result holds; the row register and the
//   input register keep filling, so stall reaches req_stall only when a
//   third finished row has nowhere to go.
// - Synchronous reset clears the row position, the find_minimum bit and
//   all stage valids.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_quarter_extreme_mean_core import cqem_pkg::*; #(
   parameter int MONTHS = 12
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data,
   input  wire logic    csr_write_enable,
   input  wire logic    csr_write_data
);

   logic    find_min_ff;
   logic    fin_valid, fin_take, rsp_free;
   fin_type fin_data;
   logic signed [VALUE_BITS-1:0] mean;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;

   // Mode register
   always_ff @(posedge clock) begin
      if (reset) begin
         find_min_ff <= 1'b0;
      end else if (csr_write_enable) begin
         find_min_ff <= csr_write_data;
      end
   end

   // Window scan and row state
   cqem_window #(.MONTHS(MONTHS)) u_window (
      .clock        (clock),
      .reset        (reset),
      .find_minimum (find_min_ff),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .fin_valid    (fin_valid),
      .fin_take     (fin_take),
      .fin_data     (fin_data)
   );

   // Quarter mean
   cqem_div3 u_div3 (
      .sum      (fin_data.average_sum),
      .quotient (mean)
   );

   // Result register: load when empty or being taken
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   assign fin_take = rsp_free;

   always_comb begin
      rsp_data_in.quarter_start = fin_data.start;
      rsp_data_in.quarter_avg   = fin_data.missing ? '0 : mean;
      rsp_data_in.mean_missing  = fin_data.missing;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_free) begin
         rsp_valid_ff <= fin_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_free && fin_valid) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // A missing mean always reads as zero
   a_missing_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.mean_missing |-> rsp_data_ff.quarter_avg == '0)
      else $error("missing mean not zero");

   // A present mean always names a real quarter
   a_start_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_data_ff.mean_missing |-> 32'(rsp_data_ff.quarter_start) < MONTHS)
      else $error("quarter start out of range");

   // Hold a stalled result unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_stall |=> rsp_valid_ff && $stable(rsp_data_ff))
      else $error("stalled result changed");

endmodule

`default_nettype wire
